@@ rtl/cdc_pkg.sv @@
// Shared types, codes and calendar helpers for the calendar date counter.
// Used by cdc_ctrl, cdc_dpath and calendar_date_counter_unit; no dependencies.
package cdc_pkg;

  localparam int ADD_COUNT_BITS_DEF = 16;

  // operation codes
  localparam logic [1:0] FUNC_SET = 2'd0;
  localparam logic [1:0] FUNC_INC = 2'd1;
  localparam logic [1:0] FUNC_ADD = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MONTH = 3'd1;
  localparam logic [2:0] ST_BAD_YEAR  = 3'd2;
  localparam logic [2:0] ST_BAD_DAY   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  localparam logic [11:0] YEAR_MIN = 12'd1900;
  localparam logic [11:0] YEAR_MID = 12'd2000;
  localparam logic [11:0] YEAR_MAX = 12'd2100;
  localparam logic [11:0] YEAR_TOP = 12'd4095;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [11:0] new_year;
    logic [15:0] days_to_add;
  } cdc_in_t;

  typedef struct packed {
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [11:0] cur_year;
    logic [2:0]  status;
    logic        is_leap;
  } cdc_out_t;

  // controller to datapath
  typedef struct packed {
    logic ld_set;   // check and load a date
    logic ld_one;   // arm an advance of one day
    logic ld_add;   // arm an advance of days_to_add days
    logic ld_nop;   // unused selector: report as is
    logic step;     // one month-sized step of an advance
  } cdc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fin;      // the current step ends the advance
  } cdc_sts_t;

  // days in a month; 0 for codes that are no month
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    begin
      case (month)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
        4'd2:                                       d = leap ? 5'd29 : 5'd28;
        default:                                    d = 5'd0;
      endcase
      return d;
    end
  endfunction

endpackage

@@ rtl/calendar_date_counter_unit.sv @@
// Top level of the calendar date counter: Gregorian date register with set,
// increment and add-days operations. Depends on cdc_pkg, cdc_ctrl, cdc_dpath.
//
//   channel  ports                    beat taken when
//   -------  -----------------------  ---------------------------
//   input    start, busy, in_data     start high while busy low
//   result   out_valid, out_data      out_valid high (one cycle)
//
// Order: a set or an unused selector puts its result out in the cycle right
// after the accepting edge; the next beat is taken only after that cycle.
// An increment or add first runs one step for each month touched (one
// month-sized step per cycle of the datapath, at least one step), then puts
// its result out; a new beat is taken only after the result cycle.
// busy stays high from the edge that accepts a beat through the result cycle.
// Reset (rst_n low, synchronous) loads 1 January 1900 with status ok.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
module calendar_date_counter_unit #(
  parameter int ADD_COUNT_BITS = cdc_pkg::ADD_COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cdc_pkg::cdc_in_t  in_data,
  output logic              out_valid,
  output cdc_pkg::cdc_out_t out_data
);

  cdc_pkg::cdc_cmd_t cmd;
  cdc_pkg::cdc_sts_t sts;

  // sequence the operation
  cdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (in_data.func),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // hold the date; step it a month at a time
  cdc_dpath #(
    .ADD_COUNT_BITS (ADD_COUNT_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

@@ rtl/cdc_ctrl.sv @@
// Sequencer of the calendar date counter: accepts a beat, runs the datapath
// steps of an increment or add and emits the result strobe. Depends on cdc_pkg.
module cdc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        func,
  input  cdc_pkg::cdc_sts_t sts,
  output cdc_pkg::cdc_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       take;

  assign take = start && (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          case (func)
            cdc_pkg::FUNC_SET: begin
              cmd.ld_set = 1'b1;
              state_nxt  = S_OUT;
            end
            cdc_pkg::FUNC_INC: begin
              cmd.ld_one = 1'b1;
              state_nxt  = S_RUN;
            end
            cdc_pkg::FUNC_ADD: begin
              cmd.ld_add = 1'b1;
              state_nxt  = S_RUN;
            end
            default: begin
              cmd.ld_nop = 1'b1;
              state_nxt  = S_OUT;
            end
          endcase
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.fin) state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

@@ rtl/cdc_dpath.sv @@
// Date registers, day counter and leap tracking of the calendar date counter.
// Driven by cdc_ctrl through cdc_cmd_t. Depends on cdc_pkg.
module cdc_dpath #(
  parameter int ADD_COUNT_BITS = cdc_pkg::ADD_COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cdc_pkg::cdc_in_t  in_data,
  input  cdc_pkg::cdc_cmd_t cmd,
  output cdc_pkg::cdc_sts_t sts,
  output cdc_pkg::cdc_out_t out_data
);

  localparam int CW = (ADD_COUNT_BITS > 6) ? ADD_COUNT_BITS : 6;
  localparam int TB = (ADD_COUNT_BITS < 16) ? ADD_COUNT_BITS : 16;

  logic [4:0]    day_r, day_nxt;
  logic [3:0]    month_r, month_nxt;
  logic [11:0]   year_r, year_nxt;
  logic [6:0]    yic_r, yic_nxt;     // year within century, 0..99
  logic [1:0]    cent_r, cent_nxt;   // century number mod 4
  logic [2:0]    status_r, status_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          leap_cur;
  logic [4:0]    dim_cur;
  logic [4:0]    left;
  logic          fits;

  // set checks
  logic          m_bad, y_bad, d_bad, leap_new;
  logic [6:0]    yic_new;
  logic [1:0]    cent_new;

  assign leap_cur = (yic_r == 7'd0) ? (cent_r == 2'd0) : (yic_r[1:0] == 2'd0);
  assign dim_cur  = cdc_pkg::days_in(month_r, leap_cur);
  assign left     = (day_r < dim_cur) ? (dim_cur - day_r) : 5'd0;
  assign fits     = (cnt_r <= CW'(left));

  // a checked year lies in 1900..2100, where only 2000 is a century leap year
  assign m_bad    = (in_data.new_month == 4'd0) || (in_data.new_month > 4'd12);
  assign y_bad    = (in_data.new_year < cdc_pkg::YEAR_MIN) ||
                    (in_data.new_year > cdc_pkg::YEAR_MAX);
  assign leap_new = (in_data.new_year[1:0] == 2'd0) &&
                    (in_data.new_year != cdc_pkg::YEAR_MIN) &&
                    (in_data.new_year != cdc_pkg::YEAR_MAX);
  assign d_bad    = (in_data.new_day == 5'd0) ||
                    (in_data.new_day > cdc_pkg::days_in(in_data.new_month, leap_new));

  always_comb begin
    if (in_data.new_year < cdc_pkg::YEAR_MID) begin
      yic_new  = 7'(in_data.new_year - cdc_pkg::YEAR_MIN);
      cent_new = 2'd3;
    end else if (in_data.new_year < cdc_pkg::YEAR_MAX) begin
      yic_new  = 7'(in_data.new_year - cdc_pkg::YEAR_MID);
      cent_new = 2'd0;
    end else begin
      yic_new  = 7'(in_data.new_year - cdc_pkg::YEAR_MAX);
      cent_new = 2'd1;
    end
  end

  always_comb begin
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    yic_nxt    = yic_r;
    cent_nxt   = cent_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    sts.fin    = 1'b0;

    if (cmd.ld_set) begin
      if (m_bad)      status_nxt = cdc_pkg::ST_BAD_MONTH;
      else if (y_bad) status_nxt = cdc_pkg::ST_BAD_YEAR;
      else if (d_bad) status_nxt = cdc_pkg::ST_BAD_DAY;
      else begin
        status_nxt = cdc_pkg::ST_OK;
        day_nxt    = in_data.new_day;
        month_nxt  = in_data.new_month;
        year_nxt   = in_data.new_year;
        yic_nxt    = yic_new;
        cent_nxt   = cent_new;
      end
    end else if (cmd.ld_one) begin
      status_nxt = cdc_pkg::ST_OK;
      cnt_nxt    = CW'(1);
    end else if (cmd.ld_add) begin
      status_nxt = cdc_pkg::ST_OK;
      cnt_nxt    = CW'(in_data.days_to_add[TB-1:0]);
    end else if (cmd.ld_nop) begin
      status_nxt = cdc_pkg::ST_OK;
    end else if (cmd.step) begin
      if (fits) begin
        // remainder lands inside this month
        day_nxt = day_r + cnt_r[4:0];
        sts.fin = 1'b1;
      end else if (month_r >= 4'd12) begin
        if (year_r == cdc_pkg::YEAR_TOP) begin
          day_nxt    = 5'd31;
          month_nxt  = 4'd12;
          status_nxt = cdc_pkg::ST_OVERFLOW;
          sts.fin    = 1'b1;
        end else begin
          year_nxt  = year_r + 12'd1;
          month_nxt = 4'd1;
          day_nxt   = 5'd1;
          cnt_nxt   = cnt_r - CW'(left) - CW'(1);
          if (yic_r == 7'd99) begin
            yic_nxt  = 7'd0;
            cent_nxt = cent_r + 2'd1;
          end else begin
            yic_nxt = yic_r + 7'd1;
          end
        end
      end else begin
        month_nxt = month_r + 4'd1;
        day_nxt   = 5'd1;
        cnt_nxt   = cnt_r - CW'(left) - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r    <= 5'd1;
      month_r  <= 4'd1;
      year_r   <= cdc_pkg::YEAR_MIN;
      yic_r    <= 7'd0;
      cent_r   <= 2'd3;
      status_r <= cdc_pkg::ST_OK;
    end else begin
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      yic_r    <= yic_nxt;
      cent_r   <= cent_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

  assign out_data.cur_month = month_r;
  assign out_data.cur_day   = day_r;
  assign out_data.cur_year  = year_r;
  assign out_data.status    = status_r;
  assign out_data.is_leap   = leap_cur;

endmodule
